FILE: design/lphs_pkg.sv
// lphs_pkg: shared types and constants for the linear probing hash set
// used by linear_probe_hash_set and its testbench; no dependencies
package lphs_pkg;

  // number of slots; the home slot is the low key bits, so this stays a power of two
  localparam int TABLE_SIZE = 1024;
  localparam int ADDR_W     = $clog2(TABLE_SIZE);
  localparam int KEY_W      = 31;
  localparam int SLOT_W     = 10;
  localparam int OP_W       = 2;
  localparam int ENTRY_W    = KEY_W + 1;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic              table_full;
    logic [SLOT_W-1:0] slot_index;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } slot_entry_t;

endpackage

FILE: design/linear_probe_hash_set.sv
// linear_probe_hash_set: open addressing hash set with linear probing
// depends on lphs_pkg and lphs_ram
//
// insert/lookup: p = slots probed (1..TABLE_SIZE), one probe per cycle through the
//   single slot ram port
// clear: a sweep writes one slot per cycle; other codes give an all-zero result without probing
// one item at a time: in_stall is high until the result sits in the output register;
//   the next item can be taken while that result waits there
// reset: a sweep over all TABLE_SIZE slots empties the ram, in_stall high throughout
module linear_probe_hash_set (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lphs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lphs_pkg::out_item_t out_data
);

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_PROBE,
    S_DONE
  } state_t;

  localparam logic [lphs_pkg::ADDR_W-1:0] LAST_SLOT =
    lphs_pkg::ADDR_W'(lphs_pkg::TABLE_SIZE - 1);

  state_t                           state_r, state_nxt;
  logic [lphs_pkg::ADDR_W-1:0]      sweep_r, sweep_nxt;      // clear sweep address
  logic                             report_r, report_nxt;    // sweep came from a clear item
  logic [lphs_pkg::ADDR_W-1:0]      pos_r, pos_nxt;          // slot being probed
  logic [lphs_pkg::ADDR_W-1:0]      probes_r, probes_nxt;    // probes already done
  logic [lphs_pkg::OP_W-1:0]        op_r, op_nxt;
  logic [lphs_pkg::KEY_W-1:0]       key_r, key_nxt;
  lphs_pkg::out_item_t              hold_r, hold_nxt;        // finished result
  logic                             out_valid_r, out_valid_nxt;
  lphs_pkg::out_item_t              out_data_r, out_data_nxt;

  logic                             ram_we;
  logic [lphs_pkg::ADDR_W-1:0]      ram_addr;
  lphs_pkg::slot_entry_t            ram_wdata;
  lphs_pkg::slot_entry_t            ram_rdata;
  logic [lphs_pkg::ADDR_W-1:0]      pos_inc;
  logic [lphs_pkg::ADDR_W-1:0]      in_home;

  // slot ram: one valid bit plus key per slot
  lphs_ram #(
    .WIDTH (lphs_pkg::ENTRY_W),
    .DEPTH (lphs_pkg::TABLE_SIZE)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // home slot is key mod table size, the low key bits
  assign in_home = lphs_pkg::ADDR_W'(in_data.key);
  // next probe position with wraparound
  assign pos_inc = (pos_r == LAST_SLOT) ? '0 : pos_r + lphs_pkg::ADDR_W'(1);

  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    report_nxt    = report_r;
    pos_nxt       = pos_r;
    probes_nxt    = probes_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_addr      = pos_r;
    ram_wdata     = '0;

    // output register drains when taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_SWEEP: begin
        // empty one slot per cycle
        ram_we    = 1'b1;
        ram_addr  = sweep_r;
        ram_wdata = '0;
        sweep_nxt = sweep_r + lphs_pkg::ADDR_W'(1);
        if (sweep_r == LAST_SLOT) begin
          sweep_nxt = '0;
          hold_nxt  = '0;
          state_nxt = report_r ? S_DONE : S_IDLE;
        end
      end

      S_IDLE: begin
        // read the home slot speculatively so the first probe has data next cycle
        ram_addr = in_home;
        if (in_valid) begin
          op_nxt     = in_data.operation;
          key_nxt    = in_data.key;
          pos_nxt    = in_home;
          probes_nxt = '0;
          unique case (in_data.operation) inside
            lphs_pkg::OP_CLEAR: begin
              report_nxt = 1'b1;
              state_nxt  = S_SWEEP;
            end
            lphs_pkg::OP_INSERT, lphs_pkg::OP_LOOKUP: begin
              state_nxt = S_PROBE;
            end
            default: begin
              // unused code: state untouched, all-zero result
              hold_nxt  = '0;
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_PROBE: begin
        // ram_rdata holds the slot at pos_r
        if (!ram_rdata.valid) begin
          // empty slot ends the chain; insert claims it
          hold_nxt.found      = 1'b0;
          hold_nxt.table_full = 1'b0;
          hold_nxt.slot_index = '0;
          if (op_r == lphs_pkg::OP_INSERT) begin
            ram_we              = 1'b1;
            ram_addr            = pos_r;
            ram_wdata.valid     = 1'b1;
            ram_wdata.key       = key_r;
            hold_nxt.slot_index = lphs_pkg::SLOT_W'(pos_r);
          end
          state_nxt = S_DONE;
        end else if (ram_rdata.key == key_r) begin
          hold_nxt.found      = 1'b1;
          hold_nxt.table_full = 1'b0;
          hold_nxt.slot_index = lphs_pkg::SLOT_W'(pos_r);
          state_nxt           = S_DONE;
        end else if (probes_r == LAST_SLOT) begin
          // every slot probed, no hit and no room
          hold_nxt.found      = 1'b0;
          hold_nxt.table_full = 1'b1;
          hold_nxt.slot_index = '0;
          state_nxt           = S_DONE;
        end else begin
          ram_addr   = pos_inc;
          pos_nxt    = pos_inc;
          probes_nxt = probes_r + lphs_pkg::ADDR_W'(1);
        end
      end

      S_DONE: begin
        // move the result into the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = hold_r;
          report_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      sweep_r     <= '0;
      report_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      report_r    <= report_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r      <= pos_nxt;
    probes_r   <= probes_nxt;
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    hold_r     <= hold_nxt;
    out_data_r <= out_data_nxt;
  end

  // items enter only between operations
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a full-table result never reports a hit or a slot
  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.table_full && (out_data.found || out_data.slot_index != '0)))
    else $error("table_full result carries found or slot_index");

  // the slot ram is only written by the sweep or by an insert probe
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_SWEEP ||
                (state_r == S_PROBE && op_r == lphs_pkg::OP_INSERT && !ram_rdata.valid)))
    else $error("unexpected slot ram write");

  // a probe step advances the position by exactly one slot with wraparound
  a_probe_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE && $past(state_r == S_PROBE) && $past(rst_n)) |->
      (pos_r == (($past(pos_r) == LAST_SLOT) ? '0 : $past(pos_r) + lphs_pkg::ADDR_W'(1))))
    else $error("probe position did not advance by one slot");

endmodule

FILE: design/lphs_ram.sv
// lphs_ram: generic single port ram with registered read
// no dependencies
module lphs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: dv/linear_probe_hash_set_tb.sv
// linear_probe_hash_set_tb: self-checking testbench for the linear probing hash set
// drives clear/insert/lookup items through the valid/stall channels and checks every result
// against a shadow slot table; depends on lphs_pkg and the linear_probe_hash_set rtl
module linear_probe_hash_set_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 11;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 20;
  localparam int LONG_HOLD      = 400;
  // a clear or a full-table probe keeps both channels quiet while it visits every slot
  localparam int WATCHDOG_LIMIT = 12 * (lphs_pkg::TABLE_SIZE + LONG_HOLD);
  localparam logic [lphs_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_t;

  // shadow copy of the slot table; predicts one result per accepted item
  class hash_set_scoreboard;
    bit                         shadow_valid[lphs_pkg::TABLE_SIZE];
    logic [lphs_pkg::KEY_W-1:0] shadow_key[lphs_pkg::TABLE_SIZE];
    lphs_pkg::out_item_t        expected_replies[$];
    int                         errors;

    function lphs_pkg::out_item_t predict_reply(lphs_pkg::in_item_t req);
      lphs_pkg::out_item_t r;
      int unsigned         pos;
      bit                  stopped;
      r = '0;
      stopped = 1'b0;
      case (req.operation) inside
        lphs_pkg::OP_CLEAR: shadow_valid = '{default: 1'b0};
        lphs_pkg::OP_INSERT, lphs_pkg::OP_LOOKUP: begin
          pos = req.key % lphs_pkg::TABLE_SIZE;
          for (int n = 0; n < lphs_pkg::TABLE_SIZE && !stopped; n++) begin
            if (!shadow_valid[pos]) begin
              // empty slot ends the chain; insert claims it
              if (req.operation == lphs_pkg::OP_INSERT) begin
                shadow_valid[pos] = 1'b1;
                shadow_key[pos]   = req.key;
                r.slot_index      = lphs_pkg::SLOT_W'(pos);
              end
              stopped = 1'b1;
            end else if (shadow_key[pos] == req.key) begin
              r.found      = 1'b1;
              r.slot_index = lphs_pkg::SLOT_W'(pos);
              stopped      = 1'b1;
            end else begin
              pos = (pos + 1) % lphs_pkg::TABLE_SIZE;
            end
          end
          r.table_full = !stopped;
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(lphs_pkg::in_item_t req);
      expected_replies.push_back(predict_reply(req));
    endfunction

    function void flag_mismatch(string field, int unsigned want, int unsigned got);
      errors++;
      if (errors <= 40)
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    endfunction

    function void check_reply(lphs_pkg::out_item_t got);
      lphs_pkg::out_item_t want;
      if (expected_replies.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: result with nothing expected, actual found=%0b full=%0b slot=%0d",
                   $time, got.found, got.table_full, got.slot_index);
        return;
      end
      want = expected_replies.pop_front();
      if (got.found !== want.found) flag_mismatch("found", want.found, got.found);
      if (got.table_full !== want.table_full)
        flag_mismatch("table_full", want.table_full, got.table_full);
      if (got.slot_index !== want.slot_index)
        flag_mismatch("slot_index", want.slot_index, got.slot_index);
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  lphs_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  lphs_pkg::out_item_t out_data;

  hash_set_scoreboard board;

  // stimulus shaping knobs, set per phase by the main sequence
  idle_mode_t                 tx_mode = IDLE_LIGHT;
  idle_mode_t                 rx_mode = IDLE_LIGHT;
  int                         hold_request = 0;
  int                         cluster_base = 0;
  logic [lphs_pkg::KEY_W-1:0] stored_keys[$];

  // receiver-side counters
  int rx_left = 0;
  int quiet_cycles = 0;

  linear_probe_hash_set dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 150);
  endfunction

  function automatic int tx_gap();
    case (tx_mode)
      IDLE_NONE:  return 0;
      IDLE_LIGHT: return ($urandom_range(0, 99) < 70) ? 0 : pick_gap();
      default:    return pick_gap();
    endcase
  endfunction

  // random upper bits over a chosen home slot
  function automatic logic [lphs_pkg::KEY_W-1:0] key_with_home(int home);
    logic [lphs_pkg::KEY_W-1:0] k;
    k = lphs_pkg::KEY_W'($urandom);
    k[lphs_pkg::ADDR_W-1:0] = lphs_pkg::ADDR_W'(home % lphs_pkg::TABLE_SIZE);
    return k;
  endfunction

  function automatic logic [lphs_pkg::KEY_W-1:0] stored_pick();
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  // mix of clustered keys (long probe chains), known keys (hits) and wide random keys
  function automatic lphs_pkg::in_item_t random_request();
    lphs_pkg::in_item_t req;
    int                 r;
    r = $urandom_range(0, 99);
    req.key = lphs_pkg::KEY_W'($urandom);
    if (r < 2) begin
      req.operation = lphs_pkg::OP_CLEAR;
    end else if (r < 5) begin
      req.operation = OP_UNUSED;
    end else if (r < 50) begin
      req.operation = lphs_pkg::OP_INSERT;
      if (r < 12 && stored_keys.size() != 0) req.key = stored_pick();
      else if (r < 38) req.key = key_with_home(cluster_base + $urandom_range(0, 23));
    end else begin
      req.operation = lphs_pkg::OP_LOOKUP;
      if (r < 80 && stored_keys.size() != 0) req.key = stored_pick();
      else if (r < 92) req.key = key_with_home(cluster_base + $urandom_range(0, 23));
    end
    return req;
  endfunction

  // offer one item, hold it until accepted, then hand it to the scoreboard
  task automatic send_request(input lphs_pkg::in_item_t req);
    int gap;
    gap = tx_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    // in_stall read right after the edge is its value at the edge
    do @(posedge clk); while (in_stall);
    board.note_request(req);
    if (req.operation == lphs_pkg::OP_CLEAR) begin
      stored_keys.delete();
    end else if (req.operation == lphs_pkg::OP_INSERT) begin
      stored_keys.push_back(req.key);
      if (stored_keys.size() > 64) void'(stored_keys.pop_front());
    end
  endtask

  // builds an item from its fields and sends it
  task automatic send_op(input logic [lphs_pkg::OP_W-1:0] op,
                         input logic [lphs_pkg::KEY_W-1:0] key);
    lphs_pkg::in_item_t req;
    req.operation = op;
    req.key       = key;
    send_request(req);
  endtask

  // sender goes quiet until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // result monitor and receiver stall pattern
  always @(posedge clk) begin
    if (out_valid && !out_stall) board.check_reply(out_data);
    if (hold_request != 0) begin
      // long hold counted here while the sender keeps offering items
      out_stall    <= 1'b1;
      rx_left      = hold_request;
      hold_request = 0;
    end else if (rx_left != 0) begin
      rx_left--;
    end else if (out_stall || rx_mode == IDLE_NONE) begin
      out_stall <= 1'b0;
      rx_left   = $urandom_range(2, 40);
    end else begin
      out_stall <= ($urandom_range(0, 99) < (rx_mode == IDLE_HEAVY ? 60 : 25));
      rx_left   = pick_gap();
    end
  end

  // watchdog: too long with no item moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [lphs_pkg::KEY_W-1:0] probe_key;
    board = new;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extreme keys, duplicates, wraparound, unused code, clear
    send_op(lphs_pkg::OP_LOOKUP, 31'h0000_0000);  // miss on empty table
    send_op(lphs_pkg::OP_INSERT, 31'h0000_0000);
    send_op(lphs_pkg::OP_INSERT, 31'h0000_0000);  // already present
    send_op(lphs_pkg::OP_INSERT, 31'h7FFF_FFFF);  // home is the last slot
    send_op(lphs_pkg::OP_INSERT, 31'h7FFF_FBFF);  // same home, wraps past slot 0
    send_op(lphs_pkg::OP_LOOKUP, 31'h7FFF_FBFF);
    send_op(lphs_pkg::OP_LOOKUP, 31'h0000_03FF);  // wrapped chain, ends empty
    send_op(OP_UNUSED, 31'h7FFF_FFFF);
    send_op(OP_UNUSED, 31'h0000_0000);
    send_op(lphs_pkg::OP_LOOKUP, 31'h7FFF_FFFF);
    send_op(lphs_pkg::OP_INSERT, 31'h5555_5555);
    send_op(lphs_pkg::OP_INSERT, 31'h2AAA_AAAA);
    send_op(lphs_pkg::OP_LOOKUP, 31'h5555_5555);
    send_op(lphs_pkg::OP_CLEAR,  31'h7FFF_FFFF);
    send_op(lphs_pkg::OP_LOOKUP, 31'h0000_0000);  // gone after clear
    send_op(lphs_pkg::OP_LOOKUP, 31'h7FFF_FFFF);
    send_op(lphs_pkg::OP_INSERT, 31'h0000_0400);
    drain();

    // fill every slot, then hit the full table on insert and on lookup
    send_op(lphs_pkg::OP_CLEAR, lphs_pkg::KEY_W'($urandom));
    for (int i = 0; i < lphs_pkg::TABLE_SIZE; i++)
      send_op(lphs_pkg::OP_INSERT, key_with_home(i));
    probe_key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    // full, no write
    send_op(lphs_pkg::OP_INSERT, probe_key ^ lphs_pkg::KEY_W'(lphs_pkg::TABLE_SIZE));
    // full, absent
    send_op(lphs_pkg::OP_LOOKUP, probe_key ^ lphs_pkg::KEY_W'(lphs_pkg::TABLE_SIZE));
    send_op(lphs_pkg::OP_LOOKUP, probe_key);  // present
    send_op(lphs_pkg::OP_INSERT, probe_key);  // present on full
    send_op(lphs_pkg::OP_LOOKUP, 31'h7FFF_FFFF);
    send_op(lphs_pkg::OP_CLEAR, lphs_pkg::KEY_W'($urandom));
    drain();

    // random phases with different idle patterns on each side
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin tx_mode = IDLE_NONE;  rx_mode = IDLE_NONE;  end
        1: begin tx_mode = IDLE_LIGHT; rx_mode = IDLE_LIGHT; end
        2: begin tx_mode = IDLE_NONE;  rx_mode = IDLE_HEAVY; end
        3: begin tx_mode = IDLE_HEAVY; rx_mode = IDLE_NONE;  end
        4: begin tx_mode = IDLE_HEAVY; rx_mode = IDLE_HEAVY; end
        default: begin tx_mode = IDLE_LIGHT; rx_mode = idle_mode_t'($urandom_range(0, 2)); end
      endcase
      // some phases cluster near the top so chains wrap to slot 0
      cluster_base = (phase % 3 == 1) ? lphs_pkg::TABLE_SIZE - $urandom_range(4, 12)
                                      : $urandom_range(0, lphs_pkg::TABLE_SIZE - 1);
      // receiver blocks for a long time while the sender keeps pushing
      if (phase == 2) hold_request = LONG_HOLD;
      for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_request());
      drain();
    end

    // anything late or extra would show up as an unexpected result here
    repeat (lphs_pkg::TABLE_SIZE + 8) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
